/* rtl/rcppm_pkg.sv */
package rcppm_pkg;

    // Item kinds carried on the input tuser
    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_LOAD    = 2'd1,
        FUNC_COMMIT  = 2'd2,
        FUNC_TIMEOUT = 2'd3
    } func_t;

    // Configuration register indexes
    localparam logic [2:0] REG_FRAME_INTERVAL      = 3'd0;
    localparam logic [2:0] REG_FRAME_INTERVAL_LONG = 3'd1;
    localparam logic [2:0] REG_SYNC_MINIMUM        = 3'd2;
    localparam logic [2:0] REG_PULSE_WIDTH         = 3'd3;
    localparam logic [2:0] REG_VALUE_MINIMUM       = 3'd4;
    localparam logic [2:0] REG_VALUE_MAXIMUM       = 3'd5;
    localparam logic [2:0] REG_TIMEOUT_ENABLE      = 3'd6;

    // Reset values
    localparam logic [15:0] RST_FRAME_INTERVAL      = 16'd45000;
    localparam logic [15:0] RST_FRAME_INTERVAL_LONG = 16'd50000;
    localparam logic [15:0] RST_SYNC_MINIMUM        = 16'd6000;
    localparam logic [15:0] RST_PULSE_WIDTH         = 16'd600;
    localparam logic [15:0] RST_VALUE_MINIMUM       = 16'd1600;
    localparam logic [15:0] RST_VALUE_MAXIMUM       = 16'd4400;
    localparam logic        RST_TIMEOUT_ENABLE      = 1'b1;

    // Compare value that never matches: pulse suppressed
    localparam logic [15:0] NO_PULSE = 16'hFFFF;

    typedef struct packed {
        logic [15:0] frame_interval;
        logic [15:0] frame_interval_long;
        logic [15:0] sync_minimum;
        logic [15:0] pulse_width;
        logic [15:0] value_minimum;
        logic [15:0] value_maximum;
        logic        timeout_enable;
    } cfg_t;

    typedef struct packed {
        func_t       func;
        logic [3:0]  channel_index;
        logic [15:0] raw_value;
        logic [7:0]  channel_count;
    } item_t;

    typedef struct packed {
        logic [15:0] period_ticks;
        logic [15:0] compare_ticks;
        logic        is_sync;
        logic        pulse_active;
    } result_t;

endpackage

/* rtl/rcppm_seq.sv */
module rcppm_seq #(
    parameter int MAX_CHANNELS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rcppm_pkg::cfg_t    cfg,
    input  logic              item_en,
    input  rcppm_pkg::item_t   item,
    output rcppm_pkg::result_t result
);
    import rcppm_pkg::*;

    localparam logic [7:0] COUNT_LIMIT = 8'(MAX_CHANNELS);

    logic [4:0]  slot_counter_reg, slot_counter_next;
    logic [15:0] frame_total_reg, frame_total_next;
    logic [15:0] next_period_reg, next_period_next;
    logic        output_muted_reg, output_muted_next;
    logic        timed_out_reg, timed_out_next;
    logic        active_bank_reg, active_bank_next;
    logic [4:0]  bank_count_reg [2];
    logic [4:0]  commit_count;

    // Two banks of 16 slots; bank is the top address bit
    logic [15:0] channel_store [32];

    logic [15:0] load_doubled;
    logic [15:0] load_raised;
    logic [15:0] load_value;
    logic [15:0] slot_value;
    logic [16:0] total_plus_min;
    logic        use_long;

    always_comb
    begin
        load_doubled = {item.raw_value[14:0], 1'b0};
        load_raised  = (load_doubled < cfg.value_minimum) ? cfg.value_minimum : load_doubled;
        load_value   = (load_raised > cfg.value_maximum) ? cfg.value_maximum : load_raised;
        commit_count = (item.channel_count > COUNT_LIMIT) ? COUNT_LIMIT[4:0]
                                                          : item.channel_count[4:0];
        slot_value   = channel_store[{active_bank_reg, slot_counter_reg[3:0]}];
        // frame_total > interval - minimum, without a signed subtract
        total_plus_min = {1'b0, frame_total_reg} + {1'b0, cfg.sync_minimum};
        use_long       = total_plus_min > {1'b0, cfg.frame_interval};
    end

    always_comb
    begin
        slot_counter_next  = slot_counter_reg;
        frame_total_next   = frame_total_reg;
        next_period_next   = next_period_reg;
        output_muted_next  = output_muted_reg;
        timed_out_next     = timed_out_reg;
        active_bank_next   = active_bank_reg;
        result.period_ticks  = next_period_reg;
        result.compare_ticks = NO_PULSE;
        result.is_sync       = 1'b0;
        result.pulse_active  = 1'b0;
        unique case (item.func)
            FUNC_TICK:
            begin
                if (slot_counter_reg < bank_count_reg[active_bank_reg])
                begin
                    next_period_next  = slot_value;
                    frame_total_next  = frame_total_reg + slot_value;
                    slot_counter_next = slot_counter_reg + 5'd1;
                    if (!output_muted_reg)
                    begin
                        result.compare_ticks = slot_value - cfg.pulse_width;
                        result.pulse_active  = 1'b1;
                    end
                end
                else
                begin
                    next_period_next  = use_long ? cfg.frame_interval_long - frame_total_reg
                                                 : cfg.frame_interval - frame_total_reg;
                    frame_total_next  = '0;
                    slot_counter_next = '0;
                    output_muted_next = timed_out_reg;
                    result.is_sync    = 1'b1;
                    if (!timed_out_reg)
                    begin
                        result.compare_ticks = next_period_next - cfg.pulse_width;
                        result.pulse_active  = 1'b1;
                    end
                end
            end
            FUNC_COMMIT:
            begin
                active_bank_next = ~active_bank_reg;
                timed_out_next   = 1'b0;
            end
            FUNC_TIMEOUT:
            begin
                if (cfg.timeout_enable)
                    timed_out_next = 1'b1;
            end
            FUNC_LOAD:
            begin
                // store write below
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_counter_reg  <= '0;
            frame_total_reg   <= '0;
            next_period_reg   <= RST_FRAME_INTERVAL;
            output_muted_reg  <= 1'b1;
            timed_out_reg     <= 1'b1;
            active_bank_reg   <= 1'b0;
            bank_count_reg[0] <= '0;
            bank_count_reg[1] <= '0;
        end
        else if (item_en)
        begin
            slot_counter_reg <= slot_counter_next;
            frame_total_reg  <= frame_total_next;
            next_period_reg  <= next_period_next;
            output_muted_reg <= output_muted_next;
            timed_out_reg    <= timed_out_next;
            active_bank_reg  <= active_bank_next;
            if (item.func == FUNC_COMMIT)
                bank_count_reg[~active_bank_reg] <= commit_count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_en && item.func == FUNC_LOAD)
            channel_store[{~active_bank_reg, item.channel_index}] <= load_value;
    end

endmodule

/* rtl/rc_ppm_frame_generator.sv */
// RC PPM frame sequencer.
//
// Input channel (s_*): one transaction per event. s_tuser carries the kind:
// period tick, channel load, bank commit or timeout. Loads fill the
// inactive channel bank, a commit swaps banks and sets the channel count.
// Output channel (m_*): one transaction per period tick only, carrying the
// timer top and compare value for the period now starting, plus the sync
// and pulse-active flags. Loads, commits and timeouts give no output.
// Configuration: cfg_wr_en / cfg_addr / cfg_wdata, write-only, one register
// per cycle; write only while no transaction is in flight.
//
// An accepted tick passes the input register, then the output register, before m_tvalid.
// Throughput: one transaction per cycle while no tick waits on a stalled output, set
// by the single input register feeding the sequencer and the single output register.
// Stall: while an output waits, non-tick transactions still pass through;
// a tick waits in the input register and s_tready drops once it is full.
// Reset: registers return to their defaults, both banks empty, output muted
// until a commit and the following sync; channel slots are not cleared.
module rc_ppm_frame_generator #(
    parameter int MAX_CHANNELS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // channel_index[3:0], raw_value[19:4], channel_count[27:20]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // period_ticks[15:0], compare_ticks[31:16]
    output logic [1:0]  m_tuser,   // is_sync[0], pulse_active[1]
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import rcppm_pkg::*;

    cfg_t    cfg_reg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t out_reg;
    logic    out_valid_reg;
    result_t seq_result;
    logic    out_free;
    logic    proc;

    // Output slot frees when empty or being taken this cycle
    assign out_free = !out_valid_reg || m_tready;
    // Only ticks need the output slot
    assign proc     = in_valid_reg && ((in_item_reg.func != FUNC_TICK) || out_free);
    assign s_tready = !in_valid_reg || proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_interval      <= RST_FRAME_INTERVAL;
            cfg_reg.frame_interval_long <= RST_FRAME_INTERVAL_LONG;
            cfg_reg.sync_minimum        <= RST_SYNC_MINIMUM;
            cfg_reg.pulse_width         <= RST_PULSE_WIDTH;
            cfg_reg.value_minimum       <= RST_VALUE_MINIMUM;
            cfg_reg.value_maximum       <= RST_VALUE_MAXIMUM;
            cfg_reg.timeout_enable      <= RST_TIMEOUT_ENABLE;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_FRAME_INTERVAL:      cfg_reg.frame_interval      <= cfg_wdata;
                REG_FRAME_INTERVAL_LONG: cfg_reg.frame_interval_long <= cfg_wdata;
                REG_SYNC_MINIMUM:        cfg_reg.sync_minimum        <= cfg_wdata;
                REG_PULSE_WIDTH:         cfg_reg.pulse_width         <= cfg_wdata;
                REG_VALUE_MINIMUM:       cfg_reg.value_minimum       <= cfg_wdata;
                REG_VALUE_MAXIMUM:       cfg_reg.value_maximum       <= cfg_wdata;
                REG_TIMEOUT_ENABLE:      cfg_reg.timeout_enable      <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.func          <= func_t'(s_tuser);
            in_item_reg.channel_index <= s_tdata[3:0];
            in_item_reg.raw_value     <= s_tdata[19:4];
            in_item_reg.channel_count <= s_tdata[27:20];
        end
    end

    rcppm_seq #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .item_en (proc),
        .item    (in_item_reg),
        .result  (seq_result)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= proc && (in_item_reg.func == FUNC_TICK);
    end

    always_ff @(posedge clk)
    begin
        if (out_free && proc && (in_item_reg.func == FUNC_TICK))
            out_reg <= seq_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.compare_ticks, out_reg.period_ticks};
    assign m_tuser  = {out_reg.pulse_active, out_reg.is_sync};

    // Muted periods always carry the no-pulse compare
    a_muted_no_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[1]) |-> (m_tdata[31:16] == NO_PULSE))
        else $error("muted period without no-pulse compare");

    // Input only stalls behind a tick blocked by a waiting output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && (in_item_reg.func == FUNC_TICK)
                       && out_valid_reg && !m_tready))
        else $error("input stalled without cause");

    // A processed tick always lands in the output register
    a_tick_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && (in_item_reg.func == FUNC_TICK)) |=> out_valid_reg)
        else $error("tick result lost");

    // An output taken while nothing is processed leaves the output register empty
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!proc && out_valid_reg && m_tready) |=> !out_valid_reg)
        else $error("output without a tick");

endmodule
